>>> design/mcr_pkg.sv
// Package for the midpoint circle rasterizer: widths, request and set codes,
// and the set descriptor word passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package mcr_pkg;

  localparam int COORD_BITS = 12;
  localparam int OUT_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 2;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  localparam int DEC_INIT   = 1;
  localparam int DEC_ADD_LT = 3;
  localparam int DEC_ADD_GE = 5;

  localparam logic [2:0] LAST_PIXEL   = 3'd0;
  localparam logic [2:0] LAST_SPAN    = 3'd3;
  localparam logic [2:0] LAST_OUTLINE = 3'd7;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_OUTLINE,
    KIND_SPAN
  } set_kind_t;

  typedef struct packed {
    set_kind_t                      kind;
    logic signed [COORD_BITS-1:0]   cx;
    logic signed [COORD_BITS-1:0]   cy;
    logic signed [COORD_BITS-1:0]   x;
    logic signed [COORD_BITS-1:0]   y;
    logic                           done;
  } set_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> design/mcr_front.sv
// Front end: accepts request words, runs the midpoint decision update
// and pushes one set descriptor per drawing item. Uses mcr_pkg.
`timescale 1ns / 1ps

module mcr_front import mcr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         req_type,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] radius,
  input  logic                         fill_mode,
  output logic                         push,
  output set_t                         push_data
);

  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] x;
  logic signed [COORD_BITS-1:0] y;
  logic signed [DEC_BITS-1:0]   decision;
  logic                         filled;
  logic                         active;

  logic signed [COORD_BITS-1:0] x_next;
  logic signed [COORD_BITS-1:0] y_next;
  logic signed [DEC_BITS-1:0]   decision_next;
  logic signed [DEC_BITS-1:0]   x_ext;
  logic signed [DEC_BITS-1:0]   y_ext;
  logic signed [DEC_BITS-1:0]   diff;
  logic                         step_done;
  set_kind_t                    draw_kind;

  assign draw_kind = fill_mode ? KIND_SPAN : KIND_OUTLINE;

  always_comb begin
    x_ext = DEC_BITS'(x);
    y_ext = DEC_BITS'(y);
    diff  = x_ext - y_ext;
    if (decision < 0) begin
      decision_next = decision + (x_ext <<< 1) + DEC_BITS'(DEC_ADD_LT);
      y_next        = y;
    end else begin
      decision_next = decision + (diff <<< 1) + DEC_BITS'(DEC_ADD_GE);
      y_next        = y - COORD_BITS'(1);
    end
    x_next    = x + COORD_BITS'(1);
    step_done = !(x_next < y_next);
  end

  always_comb begin
    push           = 1'b0;
    push_data.kind = filled ? KIND_SPAN : KIND_OUTLINE;
    push_data.cx   = cx;
    push_data.cy   = cy;
    push_data.x    = x_next;
    push_data.y    = y_next;
    push_data.done = step_done;
    if (accept) begin
      if (req_type == REQ_START) begin
        push_data.cx = center_x;
        push_data.cy = center_y;
        push_data.x  = '0;
        if (radius == '0) begin
          push           = 1'b1;
          push_data.kind = KIND_PIXEL;
          push_data.y    = '0;
          push_data.done = 1'b1;
        end else begin
          push           = !radius[COORD_BITS-1];
          push_data.kind = draw_kind;
          push_data.y    = radius;
          push_data.done = 1'b0;
        end
      end else begin
        push = active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx       <= '0;
      cy       <= '0;
      x        <= '0;
      y        <= '0;
      decision <= '0;
      filled   <= 1'b0;
      active   <= 1'b0;
    end else if (accept) begin
      if (req_type == REQ_START) begin
        cx     <= center_x;
        cy     <= center_y;
        filled <= fill_mode;
        if (radius[COORD_BITS-1] || radius == '0) begin
          active <= 1'b0;
        end else begin
          x        <= '0;
          y        <= radius;
          decision <= DEC_BITS'(DEC_INIT) - DEC_BITS'(radius);
          active   <= 1'b1;
        end
      end else if (active) begin
        x        <= x_next;
        y        <= y_next;
        decision <= decision_next;
        active   <= !step_done;
      end
    end
  end

  a_active_below_diag: assert property (@(posedge clk) disable iff (rst)
    active |-> (x < y))
    else $error("active circle with x >= y");

  a_push_needs_word: assert property (@(posedge clk) disable iff (rst)
    push |-> accept)
    else $error("descriptor pushed without an accepted word");

endmodule

>>> design/mcr_queue.sv
// Short queue of set descriptors between front end and back end.
// Uses mcr_pkg.
`timescale 1ns / 1ps

module mcr_queue import mcr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_ctrl_t ctrl,
  input  set_t    wr_data,
  output set_t    rd_data,
  output q_stat_t stat
);

  set_t                  entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_PTR_BITS:0]   count;

  assign stat.full  = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= wr_ptr + Q_PTR_BITS'(1);
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr + Q_PTR_BITS'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + (Q_PTR_BITS+1)'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - (Q_PTR_BITS+1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.push && stat.full && !ctrl.pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.pop && stat.empty))
    else $error("pop from empty queue");

endmodule

>>> design/mcr_back.sv
// Back end: expands each set descriptor into pixels or spans, one result
// word per unstalled cycle, through an output register. Uses mcr_pkg.
`timescale 1ns / 1ps

module mcr_back import mcr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  set_t                       q_data,
  input  logic                       q_avail,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       is_span,
  output logic signed [OUT_BITS-1:0] row,
  output logic signed [OUT_BITS-1:0] col_left,
  output logic signed [OUT_BITS-1:0] col_right,
  output logic                       last_of_run,
  output logic                       circle_done
);

  set_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic [2:0] last_idx;
  logic       cur_last;
  logic       out_free;
  logic       advance;

  logic signed [OUT_BITS-1:0] ecx;
  logic signed [OUT_BITS-1:0] ecy;
  logic signed [OUT_BITS-1:0] ex;
  logic signed [OUT_BITS-1:0] ey;
  logic signed [OUT_BITS-1:0] a;
  logic signed [OUT_BITS-1:0] b;
  logic signed [OUT_BITS-1:0] row_next;
  logic signed [OUT_BITS-1:0] left_next;
  logic signed [OUT_BITS-1:0] right_next;

  always_comb begin
    case (cur.kind)
      KIND_PIXEL:   last_idx = LAST_PIXEL;
      KIND_SPAN:    last_idx = LAST_SPAN;
      KIND_OUTLINE: last_idx = LAST_OUTLINE;
      default:      last_idx = LAST_OUTLINE;
    endcase
  end

  assign cur_last = (idx == last_idx);
  assign out_free = !out_valid || !out_stall;
  assign advance  = cur_valid && out_free;
  assign q_pop    = q_avail && (!cur_valid || (advance && cur_last));

  always_comb begin
    ecx        = OUT_BITS'(cur.cx);
    ecy        = OUT_BITS'(cur.cy);
    ex         = OUT_BITS'(cur.x);
    ey         = OUT_BITS'(cur.y);
    a          = ey;
    b          = ex;
    row_next   = ecy;
    left_next  = ecx;
    right_next = ecx;
    case (cur.kind)
      KIND_PIXEL: begin
        row_next   = ecy;
        left_next  = ecx;
        right_next = ecx;
      end
      KIND_SPAN: begin
        a          = idx[1] ? ex : ey;
        b          = idx[1] ? ey : ex;
        row_next   = idx[0] ? (ecy - a) : (ecy + a);
        left_next  = ecx - b;
        right_next = ecx + b;
      end
      default: begin
        a          = idx[2] ? ex : ey;
        b          = idx[2] ? ey : ex;
        row_next   = idx[1] ? (ecy - a) : (ecy + a);
        left_next  = idx[0] ? (ecx - b) : (ecx + b);
        right_next = left_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (advance) begin
      if (cur_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_span     <= (cur.kind == KIND_SPAN);
      row         <= row_next;
      col_left    <= left_next;
      col_right   <= right_next;
      last_of_run <= cur_last;
      circle_done <= cur.done;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx <= last_idx))
    else $error("result index past end of set");

  a_pixel_done: assert property (@(posedge clk) disable iff (rst)
    (advance && cur.kind == KIND_PIXEL) |=> (last_of_run && circle_done && !is_span))
    else $error("centre pixel not marked final");

endmodule

>>> design/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer top level: front end, descriptor queue, back end.
// Results pass a queue entry, the back end set register and the output register in turn.
// Throughput: a step emits 8 outline pixels or 4 spans, one word per unstalled cycle from
// the back end output register; requests are taken back to back while the queue has room.
// Reset (rst, synchronous): circle state cleared to zero and idle, queue and outputs empty.
// Uses mcr_pkg, mcr_front, mcr_queue, mcr_back.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer import mcr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] radius,
  input  logic                         fill_mode,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_span,
  output logic signed [OUT_BITS-1:0]   row,
  output logic signed [OUT_BITS-1:0]   col_left,
  output logic signed [OUT_BITS-1:0]   col_right,
  output logic                         last_of_run,
  output logic                         circle_done
);

  logic    accept;
  logic    push;
  set_t    push_data;
  set_t    q_data;
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;
  logic    q_pop;

  assign in_stall    = q_stat.full;
  assign accept      = in_valid && !q_stat.full;
  assign q_ctrl.push = push;
  assign q_ctrl.pop  = q_pop;

  mcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .fill_mode (fill_mode),
    .push      (push),
    .push_data (push_data)
  );

  mcr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_data (push_data),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  mcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_data),
    .q_avail     (!q_stat.empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_span     (is_span),
    .row         (row),
    .col_left    (col_left),
    .col_right   (col_right),
    .last_of_run (last_of_run),
    .circle_done (circle_done)
  );

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |-> !push)
    else $error("descriptor pushed while input stalled");

endmodule
